// ===== rtl/assert_macros.svh =====
// assertion helpers for the odometry checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, off during reset
`define WOI_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("odometry check failed");

// next-cycle implication, off during reset
`define WOI_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("odometry check failed");

// next-cycle implication, also checked through reset
`define WOI_ASSERT_NEXT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("odometry check failed");

`endif

// ===== rtl/woi_pkg.sv =====
package woi_pkg;

    // operation codes
    localparam logic [1:0] OP_SAMPLE   = 2'd0;
    localparam logic [1:0] OP_UPDATE   = 2'd1;
    localparam logic [1:0] OP_LOAD     = 2'd2;
    localparam logic [1:0] OP_RESERVED = 2'd3;

    // register indexes
    localparam logic [2:0] REG_WRAP_THR  = 3'd0;
    localparam logic [2:0] REG_MPT       = 3'd1;
    localparam logic [2:0] REG_WHEELBASE = 3'd2;
    localparam logic [2:0] REG_INIT_X    = 3'd3;
    localparam logic [2:0] REG_INIT_Y    = 3'd4;
    localparam logic [2:0] REG_INIT_HEAD = 3'd5;

    // angle constants
    localparam int PI_Q13      = 25736;
    localparam int TWO_PI_Q13  = 51472;
    localparam logic signed [35:0] PI_Q30   = 36'sd3373268992;
    localparam logic signed [35:0] HALF_Q30 = 36'sd1686634496;
    localparam logic signed [39:0] GAIN_Q30 = 40'sd652032874;
    localparam logic [31:0] US_PER_S = 32'd1000000;

    // shared unit step counts
    localparam int MUL_STEPS = 32;
    localparam int DIV_STEPS = 51;

    typedef logic signed [71:0] prod_t;
    typedef logic signed [39:0] cxy_t;
    typedef logic signed [35:0] ang_t;

    // arctan(2^-i) in Q2.30
    function automatic logic [29:0] atan_q30(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd843314856;
            5'd1:  v = 30'd497837829;
            5'd2:  v = 30'd263043836;
            5'd3:  v = 30'd133525158;
            5'd4:  v = 30'd67021686;
            5'd5:  v = 30'd33543515;
            5'd6:  v = 30'd16775850;
            5'd7:  v = 30'd8388437;
            5'd8:  v = 30'd4194282;
            5'd9:  v = 30'd2097149;
            5'd10: v = 30'd1048575;
            5'd11: v = 30'd524287;
            5'd12: v = 30'd262143;
            5'd13: v = 30'd131071;
            5'd14: v = 30'd65535;
            5'd15: v = 30'd32767;
            5'd16: v = 30'd16383;
            5'd17: v = 30'd8191;
            5'd18: v = 30'd4095;
            5'd19: v = 30'd2047;
            5'd20: v = 30'd1023;
            5'd21: v = 30'd511;
            5'd22: v = 30'd255;
            5'd23: v = 30'd127;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

    // one 2*pi step into +-pi, Q3.13
    function automatic logic signed [15:0] wrap_q13(input logic signed [17:0] h);
        logic signed [17:0] r;
        r = h;
        if (h > 18'sd25736) begin
            r = h - 18'sd51472;
        end else if (h < -18'sd25736) begin
            r = h + 18'sd51472;
        end
        return r[15:0];
    endfunction

    // saturate to 32 bits
    function automatic logic [31:0] sat32(input logic signed [71:0] v);
        logic [31:0] r;
        r = v[31:0];
        if (v > 72'sh7FFFFFFF) begin
            r = 32'h7FFFFFFF;
        end else if (v < -72'sh80000000) begin
            r = 32'h80000000;
        end
        return r;
    endfunction

endpackage

// ===== rtl/wheel_odometry_integrator.sv =====
// channel   | port group                | word
// ----------+---------------------------+--------------------------------------
// input     | s_tvalid/s_tready/s_tdata | sample, update tick or pose load
// result    | m_tvalid/m_tready/m_tdata | pose and velocities, one per tick after a pose load
// config    | psel/penable/pwrite/paddr | six registers at byte address 4*i
//
// a wheel sample passes through decode, plus the 32-step multiply and a store when
// a distance is computed; an update tick runs the iterative cordic, then the shared
// shift-add multiplier (32 steps) for x and y and, with nonzero elapsed time, for
// both velocities, each followed by the restoring divider (51 steps)
// s_tready is high only while the sequencer is idle; one finished word waits in
// the output register while the next item is taken
// aresetn is synchronous, active low: clears pose and wheel state, sets registers to defaults
module wheel_odometry_integrator #(
    parameter int CORDIC_STAGES = 16,
    parameter int COUNT_BITS    = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [47:0]  s_tdata,   // count[15:0], elapsed_us[47:16]
    input  logic [3:0]   s_tuser,   // operation[1:0], wheel[3:2]
    output logic         m_tvalid,
    input  logic         m_tready,
    // pos_x[31:0], pos_y[63:32], heading[79:64], linear_velocity[111:80],
    // angular_velocity[143:112]
    output logic [143:0] m_tdata,
    output logic [0:0]   m_tuser,   // velocity_valid[0]
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [4:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready
);

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_DECODE = 5'd1;
    localparam logic [4:0] ST_SMUL   = 5'd2;
    localparam logic [4:0] ST_SSTORE = 5'd3;
    localparam logic [4:0] ST_PRE    = 5'd4;
    localparam logic [4:0] ST_VEC    = 5'd5;
    localparam logic [4:0] ST_AVG    = 5'd6;
    localparam logic [4:0] ST_FOLD   = 5'd7;
    localparam logic [4:0] ST_ROT    = 5'd8;
    localparam logic [4:0] ST_CSET   = 5'd9;
    localparam logic [4:0] ST_MULX   = 5'd10;
    localparam logic [4:0] ST_ADDX   = 5'd11;
    localparam logic [4:0] ST_MULY   = 5'd12;
    localparam logic [4:0] ST_ADDY   = 5'd13;
    localparam logic [4:0] ST_LMUL   = 5'd14;
    localparam logic [4:0] ST_LDIV   = 5'd15;
    localparam logic [4:0] ST_AMUL   = 5'd16;
    localparam logic [4:0] ST_ADIV   = 5'd17;
    localparam logic [4:0] ST_DONE   = 5'd18;

    localparam logic [5:0] CORDIC_LAST = 6'(CORDIC_STAGES - 1);
    localparam logic [5:0] MUL_LAST    = 6'(woi_pkg::MUL_STEPS - 1);
    localparam logic [5:0] DIV_LAST    = 6'(woi_pkg::DIV_STEPS - 1);
    localparam woi_pkg::cxy_t COUNT_MOD = 40'sd1 <<< COUNT_BITS;

    // configuration registers
    logic [14:0] wrap_thr_reg;
    logic [23:0] mpt_reg;
    logic [24:0] wheel_base_reg;
    logic [31:0] init_x_reg, init_y_reg;
    logic [15:0] init_head_reg;

    // block state
    logic [4:0]        state_reg;
    logic signed [15:0] last_cnt_reg [4];
    logic signed [31:0] wdist_reg [4];
    logic [31:0]       pose_x_reg, pose_y_reg;
    logic signed [15:0] pose_head_reg;
    logic              pose_ready_reg;

    // item registers
    logic [1:0]        wheel_reg;
    logic [15:0]       count_reg;
    logic [31:0]       el_reg;
    logic signed [31:0] cyc_reg;
    woi_pkg::cxy_t     cx_reg, cy_reg;
    woi_pkg::ang_t     cz_reg, zang_reg;
    logic              rneg_reg;
    logic [31:0]       lin_reg, ang_reg;

    // shared multiply / divide unit
    woi_pkg::prod_t    mul_a_reg, acc_reg;
    logic [31:0]       mul_b_reg;
    logic              mneg_reg;
    logic [31:0]       rem_reg;
    logic [50:0]       quo_reg;
    logic [5:0]        cnt_reg;

    // output register
    logic              m_valid_reg;
    logic [143:0]      m_data_reg;
    logic              m_vv_reg;

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_vv_reg;
    assign pready   = 1'b1;

    // register write and read
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wrap_thr_reg   <= 15'd10000;
            mpt_reg        <= 24'd41323;
            wheel_base_reg <= 25'd14287;
            init_x_reg     <= '0;
            init_y_reg     <= '0;
            init_head_reg  <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (paddr[4:2])
                woi_pkg::REG_WRAP_THR:  wrap_thr_reg   <= pwdata[14:0];
                woi_pkg::REG_MPT:       mpt_reg        <= pwdata[23:0];
                woi_pkg::REG_WHEELBASE: wheel_base_reg <= pwdata[24:0];
                woi_pkg::REG_INIT_X:    init_x_reg     <= pwdata;
                woi_pkg::REG_INIT_Y:    init_y_reg     <= pwdata;
                woi_pkg::REG_INIT_HEAD: init_head_reg  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            woi_pkg::REG_WRAP_THR:  prdata = {17'd0, wrap_thr_reg};
            woi_pkg::REG_MPT:       prdata = {8'd0, mpt_reg};
            woi_pkg::REG_WHEELBASE: prdata = {7'd0, wheel_base_reg};
            woi_pkg::REG_INIT_X:    prdata = init_x_reg;
            woi_pkg::REG_INIT_Y:    prdata = init_y_reg;
            woi_pkg::REG_INIT_HEAD: prdata = {16'd0, init_head_reg};
            default:                prdata = '0;
        endcase
    end

    // sample difference with unwrap
    logic signed [15:0] last_sel;
    woi_pkg::cxy_t      diff, diff_uw, thr_s;
    always_comb begin
        last_sel = last_cnt_reg[wheel_reg];
        thr_s    = signed'({25'd0, wrap_thr_reg});
        diff     = 40'(signed'(count_reg)) - 40'(last_sel);
        diff_uw  = diff;
        if (diff > thr_s) begin
            diff_uw = diff - COUNT_MOD;
        end else if (diff < -thr_s) begin
            diff_uw = diff + COUNT_MOD;
        end
    end

    // wheel averages
    logic signed [32:0] sum_l, sum_r, avg_l, avg_r, sum_c;
    always_comb begin
        sum_l = 33'(wdist_reg[0]) + 33'(wdist_reg[2]);
        sum_r = 33'(wdist_reg[1]) + 33'(wdist_reg[3]);
        avg_l = sum_l >>> 1;
        avg_r = sum_r >>> 1;
        sum_c = (avg_l + avg_r) >>> 1;
    end

    // cordic step, vectoring or rotation
    woi_pkg::cxy_t xs, ys, cx_step, cy_step;
    woi_pkg::ang_t at, cz_step;
    always_comb begin
        xs = cx_reg >>> cnt_reg[4:0];
        ys = cy_reg >>> cnt_reg[4:0];
        at = signed'({6'd0, woi_pkg::atan_q30(cnt_reg[4:0])});
        if (state_reg == ST_VEC) begin
            if (cy_reg > 0) begin
                cx_step = cx_reg + ys;
                cy_step = cy_reg - xs;
                cz_step = cz_reg + at;
            end else begin
                cx_step = cx_reg - ys;
                cy_step = cy_reg + xs;
                cz_step = cz_reg - at;
            end
        end else begin
            if (cz_reg >= 0) begin
                cx_step = cx_reg - ys;
                cy_step = cy_reg + xs;
                cz_step = cz_reg - at;
            end else begin
                cx_step = cx_reg + ys;
                cy_step = cy_reg - xs;
                cz_step = cz_reg + at;
            end
        end
    end

    // angle rounding and mid-cycle heading
    woi_pkg::ang_t a13, a16, avg_h;
    logic signed [17:0] head_sum;
    always_comb begin
        a13      = (zang_reg + 36'sd65536) >>> 17;
        a16      = (zang_reg + 36'sd8192) >>> 14;
        avg_h    = (cz_reg >>> 1) + (36'(pose_head_reg) <<< 17);
        head_sum = 18'(pose_head_reg) + 18'(a13);
    end

    // multiplier result with sign, position rounding
    woi_pkg::prod_t prod, prod_r30, prod_mag;
    always_comb begin
        prod     = mneg_reg ? -acc_reg : acc_reg;
        prod_r30 = (prod + (72'sd1 <<< 29)) >>> 30;
        prod_mag = acc_reg[71] ? -acc_reg : acc_reg;
    end

    // last multiply step folded into the divider load
    woi_pkg::prod_t acc_last;
    woi_pkg::prod_t prod_mag_last;
    woi_pkg::prod_t div_mag;
    logic           acc_last_neg;
    always_comb begin
        acc_last      = acc_reg + mul_a_reg;
        acc_last_neg  = acc_last[71];
        prod_mag_last = acc_last_neg ? -acc_last : acc_last;
        div_mag       = mul_b_reg[0] ? prod_mag_last : prod_mag;
    end

    // the operation code is kept from the accepted word
    logic [1:0] op_reg;
    logic       op_is_sample;
    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            op_reg <= s_tuser[1:0];
        end
    end
    assign op_is_sample = (op_reg == woi_pkg::OP_SAMPLE);

    // divider step
    logic [32:0] rem_sh;
    logic        q_bit;
    logic [32:0] rem_sub;
    always_comb begin
        rem_sh  = {rem_reg, quo_reg[50]};
        q_bit   = (rem_sh >= {1'b0, el_reg});
        rem_sub = rem_sh - {1'b0, el_reg};
    end

    // quotient saturation
    logic [50:0] q_fin;
    logic [31:0] q_sat;
    always_comb begin
        q_fin = {quo_reg[49:0], q_bit};
        if (!mneg_reg) begin
            q_sat = (q_fin > 51'h7FFFFFFF) ? 32'h7FFFFFFF : q_fin[31:0];
        end else begin
            q_sat = (q_fin > 51'h80000000) ? 32'h80000000 : -q_fin[31:0];
        end
    end

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            pose_x_reg     <= '0;
            pose_y_reg     <= '0;
            pose_head_reg  <= '0;
            pose_ready_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                last_cnt_reg[i] <= '0;
                wdist_reg[i]    <= '0;
            end
        end else begin
            if (m_valid_reg && m_tready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        wheel_reg <= s_tuser[3:2];
                        count_reg <= s_tdata[15:0];
                        el_reg    <= s_tdata[47:16];
                        case (s_tuser[1:0])
                            woi_pkg::OP_SAMPLE: state_reg <= ST_DECODE;
                            woi_pkg::OP_UPDATE: state_reg <= pose_ready_reg ? ST_PRE
                                                                           : ST_DECODE;
                            woi_pkg::OP_LOAD: begin
                                pose_x_reg     <= init_x_reg;
                                pose_y_reg     <= init_y_reg;
                                pose_head_reg  <= woi_pkg::wrap_q13(18'(signed'(init_head_reg)));
                                pose_ready_reg <= 1'b1;
                                state_reg      <= ST_DECODE;
                            end
                            default: state_reg <= ST_DECODE;
                        endcase
                    end
                end
                // handles samples; other codes just return to idle
                ST_DECODE: begin
                    state_reg <= ST_IDLE;
                end
                ST_SMUL, ST_MULX, ST_MULY, ST_LMUL, ST_AMUL: begin
                    if (mul_b_reg[0]) begin
                        acc_reg <= acc_reg + mul_a_reg;
                    end
                    mul_a_reg <= mul_a_reg <<< 1;
                    mul_b_reg <= mul_b_reg >> 1;
                    cnt_reg   <= cnt_reg + 6'd1;
                    if (cnt_reg == MUL_LAST) begin
                        cnt_reg <= '0;
                        unique case (state_reg)
                            ST_SMUL: state_reg <= ST_SSTORE;
                            ST_MULX: state_reg <= ST_ADDX;
                            ST_MULY: state_reg <= ST_ADDY;
                            ST_LMUL: state_reg <= ST_LDIV;
                            default: state_reg <= ST_ADIV;
                        endcase
                    end
                end
                ST_SSTORE: begin
                    wdist_reg[wheel_reg] <= woi_pkg::sat32((acc_reg + 72'sd128) >>> 8);
                    state_reg            <= ST_IDLE;
                end
                ST_PRE: begin
                    cyc_reg   <= sum_c[31:0];
                    cx_reg    <= signed'({15'd0, wheel_base_reg});
                    cy_reg    <= 40'(avg_r - avg_l);
                    cz_reg    <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_VEC;
                end
                ST_VEC, ST_ROT: begin
                    cx_reg  <= cx_step;
                    cy_reg  <= cy_step;
                    cz_reg  <= cz_step;
                    cnt_reg <= cnt_reg + 6'd1;
                    if (cnt_reg == CORDIC_LAST) begin
                        cnt_reg   <= '0;
                        state_reg <= (state_reg == ST_VEC) ? ST_AVG : ST_CSET;
                    end
                end
                ST_AVG: begin
                    zang_reg <= cz_reg;
                    if (avg_h > woi_pkg::PI_Q30) begin
                        cz_reg <= avg_h - (woi_pkg::PI_Q30 <<< 1);
                    end else if (avg_h < -woi_pkg::PI_Q30) begin
                        cz_reg <= avg_h + (woi_pkg::PI_Q30 <<< 1);
                    end else begin
                        cz_reg <= avg_h;
                    end
                    state_reg <= ST_FOLD;
                end
                ST_FOLD: begin
                    rneg_reg <= 1'b0;
                    if (cz_reg > woi_pkg::HALF_Q30) begin
                        cz_reg   <= cz_reg - woi_pkg::PI_Q30;
                        rneg_reg <= 1'b1;
                    end else if (cz_reg < -woi_pkg::HALF_Q30) begin
                        cz_reg   <= cz_reg + woi_pkg::PI_Q30;
                        rneg_reg <= 1'b1;
                    end
                    cx_reg    <= woi_pkg::GAIN_Q30;
                    cy_reg    <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_ROT;
                end
                // load cos times cycle distance
                ST_CSET: begin
                    mul_a_reg <= 72'(rneg_reg ? -cx_reg : cx_reg);
                    mul_b_reg <= cyc_reg[31] ? -cyc_reg : cyc_reg;
                    mneg_reg  <= cyc_reg[31];
                    acc_reg   <= '0;
                    state_reg <= ST_MULX;
                end
                ST_ADDX: begin
                    pose_x_reg <= pose_x_reg + prod_r30[31:0];
                    mul_a_reg  <= 72'(rneg_reg ? -cy_reg : cy_reg);
                    mul_b_reg  <= cyc_reg[31] ? -cyc_reg : cyc_reg;
                    acc_reg    <= '0;
                    state_reg  <= ST_MULY;
                end
                // y step, heading, then speed if time is known
                ST_ADDY: begin
                    pose_y_reg    <= pose_y_reg + prod_r30[31:0];
                    pose_head_reg <= woi_pkg::wrap_q13(head_sum);
                    mul_a_reg     <= 72'(cyc_reg);
                    mul_b_reg     <= woi_pkg::US_PER_S;
                    acc_reg       <= '0;
                    if (el_reg != 32'd0) begin
                        state_reg <= ST_LMUL;
                    end else begin
                        lin_reg   <= '0;
                        ang_reg   <= '0;
                        state_reg <= ST_DONE;
                    end
                end
                ST_LDIV, ST_ADIV: begin
                    cnt_reg <= cnt_reg + 6'd1;
                    rem_reg <= q_bit ? rem_sub[31:0] : rem_sh[31:0];
                    quo_reg <= {quo_reg[49:0], q_bit};
                    if (cnt_reg == DIV_LAST) begin
                        cnt_reg <= '0;
                        if (state_reg == ST_LDIV) begin
                            lin_reg   <= q_sat;
                            mul_a_reg <= 72'(a16);
                            mul_b_reg <= woi_pkg::US_PER_S;
                            acc_reg   <= '0;
                            state_reg <= ST_AMUL;
                        end else begin
                            ang_reg   <= q_sat;
                            state_reg <= ST_DONE;
                        end
                    end
                end
                ST_DONE: begin
                    if (!m_valid_reg || m_tready) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= {ang_reg, lin_reg, pose_head_reg,
                                        pose_y_reg, pose_x_reg};
                        m_vv_reg    <= (el_reg != 32'd0);
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
            // sample entry and divider load override the generic arms above
            if ((state_reg == ST_LMUL || state_reg == ST_AMUL) && cnt_reg == MUL_LAST) begin
                // magnitude of the finished product goes into the divider
                quo_reg  <= div_mag[50:0];
                mneg_reg <= mul_b_reg[0] ? acc_last_neg : acc_reg[71];
                rem_reg  <= '0;
            end
            if (state_reg == ST_DECODE && op_is_sample) begin
                last_cnt_reg[wheel_reg] <= signed'(count_reg);
                if (count_reg != 16'd0 && last_sel != 16'sd0) begin
                    mul_a_reg <= 72'(diff_uw);
                    mul_b_reg <= {8'd0, mpt_reg};
                    acc_reg   <= '0;
                    cnt_reg   <= '0;
                    state_reg <= ST_SMUL;
                end
            end
        end
    end

endmodule

// ===== rtl/woi_checker.sv =====
`include "assert_macros.svh"

module woi_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [143:0] m_tdata,
    input logic [0:0]   m_tuser
);

    // no word pending right after reset
    `WOI_ASSERT_NEXT_RST(a_reset_idle, !aresetn, !m_tvalid)

    // a stalled word holds
    `WOI_ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

    // every accepted item takes the sequencer out of idle
    `WOI_ASSERT_NEXT(a_busy, s_tvalid && s_tready, !s_tready)

    // without elapsed time both velocities are zero
    `WOI_ASSERT_NOW(a_vel_zero, m_tvalid && !m_tuser[0], m_tdata[143:80] == 64'd0)

endmodule

bind wheel_odometry_integrator woi_checker u_woi_checker (.*);

// ===== sim/wheel_odometry_integrator_tb.sv =====
`timescale 1ns / 100ps

module wheel_odometry_integrator_tb;

    // result fields of one pose update
    typedef struct {
        logic [31:0] px;
        logic [31:0] py;
        logic [15:0] hd;
        logic [31:0] lin;
        logic [31:0] ang;
        logic        vv;
    } pose_word_t;

    localparam longint ATAN_TAB [0:15] = '{
        843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
        16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
        65535, 32767};
    localparam longint PI30   = longint'(woi_pkg::PI_Q13) * 131072;
    localparam longint HALF30 = longint'(12868) * 131072;
    localparam int     CYCLE_LIMIT = 1000000;
    localparam int     SETTLE_CYCLES = 400;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic [47:0]  s_tdata = '0;   // count[15:0], elapsed_us[47:16]
    logic [3:0]   s_tuser = '0;   // operation[1:0], wheel[3:2]
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    // pos_x, pos_y, heading, linear_velocity, angular_velocity
    logic [143:0] m_tdata;
    logic [0:0]   m_tuser;        // velocity_valid[0]
    logic         psel = 1'b0;
    logic         penable = 1'b0;
    logic         pwrite = 1'b0;
    logic [4:0]   paddr = '0;
    logic [31:0]  pwdata = '0;
    logic [31:0]  prdata;
    logic         pready;

    wheel_odometry_integrator uut (.*);

    always #2 aclk = ~aclk;

    // shadow registers and odometry state
    longint     thr_reg, mpt_reg, base_reg, ix_reg, iy_reg, ih_reg;
    int         last_cnt [4];
    int         wheel_dist [4];
    logic [31:0] px_st, py_st;
    int         hd_st;
    bit         pose_loaded;
    int         sent_cnt [4];

    pose_word_t pose_q [$];
    int  errors = 0;
    int  words_checked = 0;
    int  samples_sent = 0;
    int  ticks_sent = 0;
    bit  quiet = 1'b0;
    bit  hold_req = 1'b0;
    int  hold_cnt = 0;
    int  stall_left = 0;
    int  cycles = 0;

    function automatic longint round_sh(longint v, int s);
        return (v + (longint'(1) << (s - 1))) >>> s;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic int wrap_pi(longint h);
        if (h > woi_pkg::PI_Q13) h -= woi_pkg::TWO_PI_Q13;
        else if (h < -woi_pkg::PI_Q13) h += woi_pkg::TWO_PI_Q13;
        return int'(h);
    endfunction

    // vectoring cordic: angle of (x, y) in Q2.30
    function automatic longint turn_angle(longint x, longint y);
        longint z, xs, ys;
        z = 0;
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0) begin
                x += ys; y -= xs; z += ATAN_TAB[i];
            end else begin
                x -= ys; y += xs; z -= ATAN_TAB[i];
            end
        end
        return z;
    endfunction

    // rotation cordic: cos and sin in Q2.30
    task automatic cos_sin(input longint z, output longint c, output longint s);
        longint x, y, xs, ys;
        bit neg;
        neg = 1'b0;
        x = 652032874;
        y = 0;
        if (z > HALF30) begin
            z -= PI30; neg = 1'b1;
        end else if (z < -HALF30) begin
            z += PI30; neg = 1'b1;
        end
        for (int i = 0; i < 16; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (z >= 0) begin
                x -= ys; y += xs; z -= ATAN_TAB[i];
            end else begin
                x += ys; y -= xs; z += ATAN_TAB[i];
            end
        end
        c = neg ? -x : x;
        s = neg ? -y : y;
    endtask

    // advance the odometry state for one accepted word
    task automatic odometry_step(input logic [1:0] op, input logic [1:0] wh,
                                 input logic [15:0] cnt_raw, input logic [31:0] el);
        longint d, l, r, cyc, z, a13, avg, c, s, lin, ang;
        int cnt;
        pose_word_t w;
        cnt = int'($signed(cnt_raw));
        lin = 0;
        ang = 0;
        if (op == woi_pkg::OP_SAMPLE) begin
            if (cnt != 0 && last_cnt[wh] != 0) begin
                d = cnt - last_cnt[wh];
                if (d > thr_reg) d -= 65536;
                else if (d < -thr_reg) d += 65536;
                wheel_dist[wh] = int'(clip32(round_sh(d * mpt_reg, 8)));
            end
            last_cnt[wh] = cnt;
        end else if (op == woi_pkg::OP_LOAD) begin
            px_st = ix_reg[31:0];
            py_st = iy_reg[31:0];
            hd_st = wrap_pi(longint'($signed(ih_reg[15:0])));
            pose_loaded = 1'b1;
        end else if (op == woi_pkg::OP_UPDATE && pose_loaded) begin
            l = (longint'(wheel_dist[0]) + wheel_dist[2]) >>> 1;
            r = (longint'(wheel_dist[1]) + wheel_dist[3]) >>> 1;
            cyc = (l + r) >>> 1;
            z = turn_angle(base_reg, r - l);
            a13 = round_sh(z, 17);
            avg = (z >>> 1) + longint'(hd_st) * 131072;
            if (avg > PI30) avg -= 2 * PI30;
            else if (avg < -PI30) avg += 2 * PI30;
            cos_sin(avg, c, s);
            px_st = px_st + 32'(round_sh(c * cyc, 30));
            py_st = py_st + 32'(round_sh(s * cyc, 30));
            hd_st = wrap_pi(hd_st + a13);
            if (el != 0) begin
                lin = clip32(cyc * 1000000 / longint'(el));
                ang = clip32(round_sh(z, 14) * 1000000 / longint'(el));
            end
            w.px = px_st;
            w.py = py_st;
            w.hd = hd_st[15:0];
            w.lin = lin[31:0];
            w.ang = ang[31:0];
            w.vv = (el != 0);
            pose_q.push_back(w);
        end
    endtask

    // offer one word and wait for it to be taken
    task automatic send_word(input logic [1:0] op, input logic [1:0] wh,
                             input logic [15:0] cnt, input logic [31:0] el);
        if (!quiet && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= {wh, op};
        s_tdata <= {el, cnt};
        do @(posedge aclk); while (!s_tready);
        if (op == woi_pkg::OP_SAMPLE) begin
            samples_sent++;
            sent_cnt[wh] = int'($signed(cnt));
        end
        if (op == woi_pkg::OP_UPDATE) ticks_sent++;
        odometry_step(op, wh, cnt, el);
    endtask

    task automatic drop_valid();
        s_tvalid <= 1'b0;
        @(posedge aclk);
    endtask

    // wait for the block to drain before touching registers
    task automatic settle();
        drop_valid();
        while (pose_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            woi_pkg::REG_WRAP_THR:  thr_reg = longint'(val & 32'h7FFF);
            woi_pkg::REG_MPT:       mpt_reg = longint'(val & 32'hFFFFFF);
            woi_pkg::REG_WHEELBASE: base_reg = longint'(val & 32'h1FFFFFF);
            woi_pkg::REG_INIT_X:    ix_reg = longint'(val);
            woi_pkg::REG_INIT_Y:    iy_reg = longint'(val);
            woi_pkg::REG_INIT_HEAD: ih_reg = longint'(val & 32'hFFFF);
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic write_all(input logic [31:0] thr, input logic [31:0] mpt,
                             input logic [31:0] base, input logic [31:0] ix,
                             input logic [31:0] iy, input logic [31:0] ih);
        reg_write(woi_pkg::REG_WRAP_THR, thr);
        reg_write(woi_pkg::REG_MPT, mpt);
        reg_write(woi_pkg::REG_WHEELBASE, base);
        reg_write(woi_pkg::REG_INIT_X, ix);
        reg_write(woi_pkg::REG_INIT_Y, iy);
        reg_write(woi_pkg::REG_INIT_HEAD, ih);
    endtask

    // encoder count that mostly moves a little from the last one
    function automatic logic [15:0] next_count(int wh);
        int r;
        r = $urandom_range(0, 19);
        if (r == 0) return 16'h0000;
        if (r == 1) return 16'($urandom);
        if (r == 2) return 16'(sent_cnt[wh] + 32768 + $urandom_range(0, 200) - 100);
        return 16'(sent_cnt[wh] + $urandom_range(0, 600) - 300);
    endfunction

    function automatic logic [31:0] next_elapsed();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0) return 32'd0;
        if (r == 1) return $urandom;
        if (r == 2) return 32'd1;
        return $urandom_range(20000, 200000);
    endfunction

    // result checker and receiver stalls
    always @(posedge aclk) begin
        pose_word_t e;
        if (aresetn && m_tvalid && m_tready) begin
            if (pose_q.size() == 0) begin
                $display("%0t: unexpected word %h", $time, m_tdata);
                errors++;
            end else begin
                e = pose_q.pop_front();
                words_checked++;
                if (m_tdata[31:0] !== e.px)
                    $display("%0t: pos_x exp %h got %h", $time, e.px, m_tdata[31:0]);
                if (m_tdata[63:32] !== e.py)
                    $display("%0t: pos_y exp %h got %h", $time, e.py, m_tdata[63:32]);
                if (m_tdata[79:64] !== e.hd)
                    $display("%0t: heading exp %h got %h", $time, e.hd, m_tdata[79:64]);
                if (m_tdata[111:80] !== e.lin)
                    $display("%0t: lin vel exp %h got %h", $time, e.lin, m_tdata[111:80]);
                if (m_tdata[143:112] !== e.ang)
                    $display("%0t: ang vel exp %h got %h", $time, e.ang,
                             m_tdata[143:112]);
                if (m_tuser[0] !== e.vv)
                    $display("%0t: vel valid exp %b got %b", $time, e.vv, m_tuser[0]);
                if (m_tdata !== {e.ang, e.lin, e.hd, e.py, e.px} || m_tuser[0] !== e.vv)
                    errors++;
            end
        end
        if (hold_req && hold_cnt < 1500) begin
            m_tready <= 1'b0;
            hold_cnt <= hold_cnt + 1;
        end else if (stall_left > 0) begin
            m_tready <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!quiet && $urandom_range(0, 7) == 0) begin
            m_tready <= 1'b0;
            stall_left <= $urandom_range(0, 14);
        end else begin
            m_tready <= 1'b1;
        end
        if (!hold_req) hold_cnt <= 0;
    end

    // run limit
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic test_tick_before_load();
        send_word(woi_pkg::OP_UPDATE, 2'd0, 16'd0, 32'd100000);
        send_word(woi_pkg::OP_SAMPLE, 2'd0, 16'd5, 32'd0);
        send_word(woi_pkg::OP_UPDATE, 2'd1, 16'd0, 32'd0);
    endtask

    task automatic test_load_and_extremes();
        send_word(woi_pkg::OP_LOAD, 2'd0, 16'd0, 32'd0);
        for (int w = 0; w < 4; w++) send_word(woi_pkg::OP_SAMPLE, 2'(w), 16'h7FFF, 32'd0);
        send_word(woi_pkg::OP_SAMPLE, 2'd0, 16'h8000, 32'd0);  // wraps upward
        send_word(woi_pkg::OP_SAMPLE, 2'd1, 16'h7F00, 32'd0);
        send_word(woi_pkg::OP_UPDATE, 2'd0, 16'd0, 32'hFFFFFFFF);
        send_word(woi_pkg::OP_SAMPLE, 2'd2, 16'd0, 32'd0);     // zero count keeps distance
        send_word(woi_pkg::OP_SAMPLE, 2'd2, 16'd100, 32'd0);   // stored zero keeps distance
        send_word(woi_pkg::OP_SAMPLE, 2'd3, 16'h8000, 32'd0);
        send_word(woi_pkg::OP_SAMPLE, 2'd3, 16'h7FFF, 32'd0);  // wraps downward
        send_word(woi_pkg::OP_UPDATE, 2'd3, 16'hFFFF, 32'd0);  // zero elapsed time
        send_word(woi_pkg::OP_UPDATE, 2'd0, 16'd0, 32'd1);
        send_word(woi_pkg::OP_RESERVED, 2'd1, 16'h1234, 32'd5); // unused code, ignored
        send_word(woi_pkg::OP_UPDATE, 2'd0, 16'd0, 32'd100000);
        settle();
    endtask

    task automatic test_config_sweep();
        // zero wheel base, tiny threshold, heading beyond pi
        write_all(32'd1, 32'hFFFFFF, 32'd0, 32'h7FFFFFFF, 32'h80000000, 32'h00007FFF);
        send_word(woi_pkg::OP_LOAD, 2'd0, 16'd0, 32'd0);
        send_word(woi_pkg::OP_SAMPLE, 2'd1, 16'd10, 32'd0);
        send_word(woi_pkg::OP_SAMPLE, 2'd1, 16'd12, 32'd0);
        send_word(woi_pkg::OP_UPDATE, 2'd0, 16'd0, 32'd50000);
        send_word(woi_pkg::OP_SAMPLE, 2'd0, 16'd10, 32'd0);
        send_word(woi_pkg::OP_SAMPLE, 2'd0, 16'd20, 32'd0);
        send_word(woi_pkg::OP_UPDATE, 2'd0, 16'd0, 32'd50000);
        settle();
        write_all(32'd32767, 32'd1, 32'h1000000, 32'h80000000, 32'h7FFFFFFF,
                  32'h00008000);
        send_word(woi_pkg::OP_LOAD, 2'd0, 16'd0, 32'd0);
        send_word(woi_pkg::OP_SAMPLE, 2'd0, 16'h8001, 32'd0);
        send_word(woi_pkg::OP_UPDATE, 2'd0, 16'd0, 32'd3);
        settle();
        write_all(32'd10000, 32'd41323, 32'd14287, 32'd0, 32'd0, 32'h00006488);
        send_word(woi_pkg::OP_LOAD, 2'd0, 16'd0, 32'd0);
    endtask

    task automatic random_run(input int n);
        int r;
        logic [1:0] wh;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            wh = 2'($urandom);
            if (r < 62)
                send_word(woi_pkg::OP_SAMPLE, wh, next_count(int'(wh)), $urandom);
            else if (r < 92)
                send_word(woi_pkg::OP_UPDATE, wh, 16'($urandom), next_elapsed());
            else if (r < 97)
                send_word(woi_pkg::OP_LOAD, wh, 16'($urandom), $urandom);
            else
                send_word(woi_pkg::OP_RESERVED, wh, 16'($urandom), $urandom);
        end
    endtask

    task automatic test_backpressure();
        hold_req <= 1'b1;
        for (int i = 0; i < 6; i++) begin
            send_word(woi_pkg::OP_SAMPLE, 2'(i), next_count(i % 4), 32'd0);
            send_word(woi_pkg::OP_UPDATE, 2'd0, 16'd0, next_elapsed());
        end
        drop_valid();
        while (pose_q.size() != 0 && hold_cnt < 1500) @(posedge aclk);
        hold_req <= 1'b0;
        settle();
    endtask

    task automatic test_random();
        random_run(180);
        settle();
        write_all($urandom_range(1, 32767), $urandom_range(1, 16777215),
                  $urandom_range(1, 16777216), $urandom, $urandom,
                  32'($signed($urandom_range(0, 51472)) - 25736));
        send_word(woi_pkg::OP_LOAD, 2'd0, 16'd0, 32'd0);
        random_run(180);
        settle();
        write_all($urandom_range(50, 20000), $urandom_range(1000, 200000),
                  $urandom_range(5000, 100000), $urandom, $urandom, $urandom);
        send_word(woi_pkg::OP_LOAD, 2'd0, 16'd0, 32'd0);
        random_run(100);
        quiet = 1'b1;
        random_run(80);
        settle();
    endtask

    initial begin
        thr_reg = 10000; mpt_reg = 41323; base_reg = 14287;
        ix_reg = 0; iy_reg = 0; ih_reg = 0;
        px_st = '0; py_st = '0; hd_st = 0; pose_loaded = 1'b0;
        for (int w = 0; w < 4; w++) begin
            last_cnt[w] = 0; wheel_dist[w] = 0; sent_cnt[w] = 0;
        end
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_tick_before_load();
        test_load_and_extremes();
        test_config_sweep();
        test_backpressure();
        test_random();
        $display("covered %0d wheel samples and %0d update ticks, %0d pose words checked",
                 samples_sent, ticks_sent, words_checked);
        $display("register sweeps included zero wheel base and threshold extremes");
        if (errors == 0 && pose_q.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
